// ===== rtl/rwsp_pkg.sv =====
// Shared types and constants for the RIFF/WAVE stream parser.
// Used by the front, queue, back and top-level modules.
`default_nettype none
package rwsp_pkg;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_DONE   = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [2:0] ERR_SMALL   = 3'd0;
    localparam logic [2:0] ERR_TAG     = 3'd1;
    localparam logic [2:0] ERR_FMT     = 3'd2;
    localparam logic [2:0] ERR_MISSING = 3'd3;
    localparam logic [2:0] ERR_FORMAT  = 3'd4;
    localparam logic [2:0] ERR_CHANS   = 3'd5;
    localparam logic [2:0] ERR_DEPTH   = 3'd6;

    localparam logic [31:0] ID_RIFF = 32'h46464952;
    localparam logic [31:0] ID_WAVE = 32'h45564157;
    localparam logic [31:0] ID_FMT  = 32'h20746D66;
    localparam logic [31:0] ID_DATA = 32'h61746164;
    localparam logic [31:0] MIN_LENGTH = 32'd44;

    typedef enum logic [6:0] {
        PH_RIFF = 7'b0000001,
        PH_SIZE = 7'b0000010,
        PH_WAVE = 7'b0000100,
        PH_HDR  = 7'b0001000,
        PH_BODY = 7'b0010000,
        PH_PAD  = 7'b0100000,
        PH_IDLE = 7'b1000000
    } phase_t;

    typedef enum logic [2:0] {
        CK_SKIP = 3'd0,
        CK_FMT  = 3'd1,
        CK_D8   = 3'd2,
        CK_D16  = 3'd3,
        CK_F32  = 3'd4
    } chunk_kind_t;

    typedef enum logic [1:0] {
        OP_D8  = 2'd0,
        OP_D16 = 2'd1,
        OP_F32 = 2'd2
    } op_t;

    // One queued command: an optional sample and an optional final result.
    typedef struct packed {
        logic        has_sample;
        op_t         op;
        logic [31:0] raw;
        logic        has_final;
        logic [1:0]  final_kind;
        logic [2:0]  code;
        logic [15:0] channels;
        logic [31:0] rate;
    } cmd_t;

    localparam int CMD_W = $bits(cmd_t);
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

    // Signed 16-bit PCM divided by 32768 as IEEE single.
    function automatic logic [31:0] pcm16_to_float(input logic [15:0] v);
        logic        s;
        logic [15:0] mag;
        logic [4:0]  msb;
        logic [22:0] man;
        logic [15:0] sh;
        begin
            s = v[15];
            mag = s ? (~v + 16'd1) : v;
            msb = 5'd0;
            for (int i = 0; i < 16; i++)
            begin
                if (mag[i])
                begin
                    msb = 5'(i);
                end
            end
            sh = mag << (5'd15 - msb);
            man = {sh[14:0], 8'd0};
            if (mag == 16'd0)
            begin
                pcm16_to_float = 32'd0;
            end
            else
            begin
                pcm16_to_float = {s, 8'(8'd112 + {3'd0, msb}), man};
            end
        end
    endfunction

    function automatic logic [31:0] pcm8_to_float(input logic [7:0] b);
        logic [15:0] v;
        begin
            v = {b ^ 8'h80, 8'd0};
            pcm8_to_float = pcm16_to_float(v);
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/rwsp_front.sv =====
// Front end: byte-level RIFF/WAVE parse state, produces queued commands.
// Depends on rwsp_pkg.
`default_nettype none
module rwsp_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic [31:0]    file_length,
    input  wire logic           take,
    input  wire logic [7:0]     data_byte,
    output logic                active,
    output rwsp_pkg::cmd_t      cmd,
    output logic                cmd_valid
);
    rwsp_pkg::phase_t      phase_reg, phase_next;
    rwsp_pkg::chunk_kind_t kind_reg, kind_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] shift_reg, shift_next;
    logic [31:0] remain_reg, remain_next;
    logic [31:0] id_reg, id_next;
    logic [31:0] off_reg, off_next;
    logic [15:0] fmt_reg, fmt_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] depth_reg, depth_next;
    logic        seen_fmt_reg, seen_fmt_next;
    logic        seen_data_reg, seen_data_next;
    logic        seen_end_reg, seen_end_next;
    logic        pad_reg, pad_next;
    logic        err_reg, err_next;
    logic [2:0]  code_reg, code_next;

    logic [31:0] sh;
    logic [31:0] pos_inc;
    logic [7:0]  tag_byte;
    logic [32:0] reach;

    assign active = !seen_end_reg && (pos_reg < file_length);
    assign sh = {data_byte, shift_reg[31:8]};
    assign pos_inc = pos_reg + 32'd1;
    assign reach = {1'b0, pos_reg} + 33'd1 + {1'b0, sh};

    always_comb
    begin
        case (pos_reg[1:0])
            2'd0: tag_byte = 8'h00;
            default: tag_byte = 8'h00;
        endcase
        if (phase_reg == rwsp_pkg::PH_RIFF)
        begin
            tag_byte = rwsp_pkg::ID_RIFF[8*pos_reg[1:0] +: 8];
        end
        else
        begin
            tag_byte = rwsp_pkg::ID_WAVE[8*pos_reg[1:0] +: 8];
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        kind_next = kind_reg;
        pos_next = pos_reg;
        shift_next = shift_reg;
        remain_next = remain_reg;
        id_next = id_reg;
        off_next = off_reg;
        fmt_next = fmt_reg;
        chan_next = chan_reg;
        rate_next = rate_reg;
        depth_next = depth_reg;
        seen_fmt_next = seen_fmt_reg;
        seen_data_next = seen_data_reg;
        seen_end_next = seen_end_reg;
        pad_next = pad_reg;
        err_next = err_reg;
        code_next = code_reg;
        cmd = '0;
        cmd_valid = 1'b0;
        if (take && active)
        begin
            if (file_length >= rwsp_pkg::MIN_LENGTH)
            begin
                shift_next = sh;
                unique case (phase_reg)
                    rwsp_pkg::PH_RIFF, rwsp_pkg::PH_WAVE:
                    begin
                        if (data_byte != tag_byte)
                        begin
                            if (!err_reg)
                            begin
                                err_next = 1'b1;
                                code_next = rwsp_pkg::ERR_TAG;
                            end
                            phase_next = rwsp_pkg::PH_IDLE;
                        end
                        else if (phase_reg == rwsp_pkg::PH_RIFF && pos_reg >= 32'd3)
                        begin
                            phase_next = rwsp_pkg::PH_SIZE;
                        end
                        else if (phase_reg == rwsp_pkg::PH_WAVE && pos_reg >= 32'd11)
                        begin
                            phase_next = rwsp_pkg::PH_HDR;
                            off_next = '0;
                        end
                    end
                    rwsp_pkg::PH_SIZE:
                    begin
                        if (pos_reg >= 32'd7)
                        begin
                            phase_next = rwsp_pkg::PH_WAVE;
                        end
                    end
                    rwsp_pkg::PH_HDR:
                    begin
                        off_next = off_reg + 32'd1;
                        if (off_next == 32'd4)
                        begin
                            id_next = sh;
                        end
                        else if (off_next >= 32'd8)
                        begin
                            remain_next = sh;
                            off_next = '0;
                            pad_next = sh[0];
                            kind_next = rwsp_pkg::CK_SKIP;
                            phase_next = (sh == 32'd0) ?
                                (sh[0] ? rwsp_pkg::PH_PAD : rwsp_pkg::PH_HDR) :
                                rwsp_pkg::PH_BODY;
                            if (reach > {1'b0, file_length})
                            begin
                                phase_next = rwsp_pkg::PH_IDLE;
                            end
                            else if (!seen_data_reg && id_reg == rwsp_pkg::ID_FMT)
                            begin
                                if (sh < 32'd16)
                                begin
                                    if (!err_reg)
                                    begin
                                        err_next = 1'b1;
                                        code_next = rwsp_pkg::ERR_FMT;
                                    end
                                    phase_next = rwsp_pkg::PH_IDLE;
                                end
                                else
                                begin
                                    kind_next = rwsp_pkg::CK_FMT;
                                    seen_fmt_next = 1'b1;
                                end
                            end
                            else if (!seen_data_reg && id_reg == rwsp_pkg::ID_DATA)
                            begin
                                if (!err_reg)
                                begin
                                    code_next = rwsp_pkg::ERR_MISSING;
                                end
                                if (!seen_fmt_reg)
                                begin
                                    phase_next = rwsp_pkg::PH_IDLE;
                                    err_next = 1'b1;
                                end
                                else if (fmt_reg != 16'd1 && fmt_reg != 16'd3)
                                begin
                                    phase_next = rwsp_pkg::PH_IDLE;
                                    err_next = 1'b1;
                                    if (!err_reg) code_next = rwsp_pkg::ERR_FORMAT;
                                end
                                else if (chan_reg == 16'd0)
                                begin
                                    phase_next = rwsp_pkg::PH_IDLE;
                                    err_next = 1'b1;
                                    if (!err_reg) code_next = rwsp_pkg::ERR_CHANS;
                                end
                                else if (fmt_reg == 16'd1 && depth_reg == 16'd16)
                                begin
                                    kind_next = rwsp_pkg::CK_D16;
                                    seen_data_next = 1'b1;
                                    code_next = code_reg;
                                end
                                else if (fmt_reg == 16'd1 && depth_reg == 16'd8)
                                begin
                                    kind_next = rwsp_pkg::CK_D8;
                                    seen_data_next = 1'b1;
                                    code_next = code_reg;
                                end
                                else if (fmt_reg == 16'd3 && depth_reg == 16'd32)
                                begin
                                    kind_next = rwsp_pkg::CK_F32;
                                    seen_data_next = 1'b1;
                                    code_next = code_reg;
                                end
                                else
                                begin
                                    phase_next = rwsp_pkg::PH_IDLE;
                                    err_next = 1'b1;
                                    if (!err_reg) code_next = rwsp_pkg::ERR_DEPTH;
                                end
                            end
                        end
                    end
                    rwsp_pkg::PH_BODY:
                    begin
                        case (kind_reg)
                            rwsp_pkg::CK_FMT:
                            begin
                                if (off_reg == 32'd1) fmt_next = sh[31:16];
                                else if (off_reg == 32'd3) chan_next = sh[31:16];
                                else if (off_reg == 32'd7) rate_next = sh;
                                else if (off_reg == 32'd15) depth_next = sh[31:16];
                            end
                            rwsp_pkg::CK_D8:
                            begin
                                cmd.has_sample = 1'b1;
                                cmd.op = rwsp_pkg::OP_D8;
                            end
                            rwsp_pkg::CK_D16:
                            begin
                                cmd.has_sample = off_reg[0];
                                cmd.op = rwsp_pkg::OP_D16;
                            end
                            rwsp_pkg::CK_F32:
                            begin
                                cmd.has_sample = (off_reg[1:0] == 2'd3);
                                cmd.op = rwsp_pkg::OP_F32;
                            end
                            default:
                            begin
                            end
                        endcase
                        cmd.raw = sh;
                        off_next = off_reg + 32'd1;
                        remain_next = remain_reg - 32'd1;
                        if (remain_next == 32'd0)
                        begin
                            off_next = '0;
                            phase_next = pad_reg ? rwsp_pkg::PH_PAD : rwsp_pkg::PH_HDR;
                        end
                    end
                    rwsp_pkg::PH_PAD:
                    begin
                        phase_next = rwsp_pkg::PH_HDR;
                        off_next = '0;
                    end
                    rwsp_pkg::PH_IDLE:
                    begin
                    end
                    default:
                    begin
                    end
                endcase
            end
            pos_next = pos_inc;
            if (pos_inc == file_length)
            begin
                seen_end_next = 1'b1;
                cmd.has_final = 1'b1;
                cmd.final_kind = rwsp_pkg::KIND_ERROR;
                if (file_length < rwsp_pkg::MIN_LENGTH)
                begin
                    cmd.code = rwsp_pkg::ERR_SMALL;
                end
                else if (err_next)
                begin
                    cmd.code = code_next;
                end
                else if (seen_fmt_next && seen_data_next)
                begin
                    cmd.final_kind = rwsp_pkg::KIND_DONE;
                    cmd.channels = chan_next;
                    cmd.rate = rate_next;
                end
                else
                begin
                    cmd.code = rwsp_pkg::ERR_MISSING;
                end
            end
            cmd_valid = cmd.has_sample || cmd.has_final;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rwsp_pkg::PH_RIFF;
            kind_reg <= rwsp_pkg::CK_SKIP;
            pos_reg <= '0;
            shift_reg <= '0;
            remain_reg <= '0;
            id_reg <= '0;
            off_reg <= '0;
            fmt_reg <= '0;
            chan_reg <= '0;
            rate_reg <= '0;
            depth_reg <= '0;
            seen_fmt_reg <= 1'b0;
            seen_data_reg <= 1'b0;
            seen_end_reg <= 1'b0;
            pad_reg <= 1'b0;
            err_reg <= 1'b0;
            code_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            kind_reg <= kind_next;
            pos_reg <= pos_next;
            shift_reg <= shift_next;
            remain_reg <= remain_next;
            id_reg <= id_next;
            off_reg <= off_next;
            fmt_reg <= fmt_next;
            chan_reg <= chan_next;
            rate_reg <= rate_next;
            depth_reg <= depth_next;
            seen_fmt_reg <= seen_fmt_next;
            seen_data_reg <= seen_data_next;
            seen_end_reg <= seen_end_next;
            pad_reg <= pad_next;
            err_reg <= err_next;
            code_reg <= code_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/rwsp_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on rwsp_pkg.
`default_nettype none
module rwsp_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  rwsp_pkg::cmd_t      push_cmd,
    input  wire logic           pop,
    output rwsp_pkg::cmd_t      head,
    output logic                not_empty,
    output logic                has_room
);
    rwsp_pkg::cmd_t slots_reg [rwsp_pkg::QUEUE_DEPTH];
    logic [rwsp_pkg::QUEUE_AW-1:0] wr_reg, rd_reg;
    logic [rwsp_pkg::QUEUE_AW:0]   count_reg, count_next;

    assign head = slots_reg[rd_reg];
    assign not_empty = (count_reg != '0);
    assign has_room = (count_reg < (rwsp_pkg::QUEUE_AW+1)'(rwsp_pkg::QUEUE_DEPTH - 1));
    assign count_next = count_reg + {{rwsp_pkg::QUEUE_AW{1'b0}}, push}
                        - {{rwsp_pkg::QUEUE_AW{1'b0}}, pop};

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop) rd_reg <= rd_reg + 1'b1;
            count_reg <= count_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/rwsp_back.sv =====
// Back end: turns queued commands into result transfers, a sample first.
// Depends on rwsp_pkg.
`default_nettype none
module rwsp_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  rwsp_pkg::cmd_t      head,
    input  wire logic           not_empty,
    output logic                pop,
    input  wire logic           stall,
    output logic                valid,
    output logic [1:0]          kind,
    output logic [31:0]         sample_bits,
    output logic [15:0]         num_channels,
    output logic [31:0]         sample_rate,
    output logic [2:0]          error_code,
    output logic                last
);
    logic        sample_done_reg;
    logic        valid_reg;
    logic [1:0]  kind_reg;
    logic [31:0] bits_reg;
    logic [15:0] chan_reg;
    logic [31:0] rate_reg;
    logic [2:0]  code_reg;
    logic        last_reg;
    logic        load;
    logic        send_sample;
    logic [31:0] conv;

    assign send_sample = head.has_sample && !sample_done_reg;
    assign load = not_empty && (!valid_reg || !stall);
    assign pop = load && !(send_sample && head.has_final);

    always_comb
    begin
        case (head.op)
            rwsp_pkg::OP_D8:  conv = rwsp_pkg::pcm8_to_float(head.raw[31:24]);
            rwsp_pkg::OP_D16: conv = rwsp_pkg::pcm16_to_float(head.raw[31:16]);
            default:          conv = head.raw;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sample_done_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                sample_done_reg <= send_sample && head.has_final;
            end
            else if (!stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (send_sample)
            begin
                kind_reg <= rwsp_pkg::KIND_SAMPLE;
                bits_reg <= conv;
                chan_reg <= '0;
                rate_reg <= '0;
                code_reg <= '0;
                last_reg <= 1'b0;
            end
            else
            begin
                kind_reg <= head.final_kind;
                bits_reg <= '0;
                chan_reg <= head.channels;
                rate_reg <= head.rate;
                code_reg <= head.code;
                last_reg <= 1'b1;
            end
        end
    end

    assign valid = valid_reg;
    assign kind = kind_reg;
    assign sample_bits = bits_reg;
    assign num_channels = chan_reg;
    assign sample_rate = rate_reg;
    assign error_code = code_reg;
    assign last = last_reg;
endmodule
`default_nettype wire

// ===== rtl/riff_wave_stream_parser.sv =====
// Top level of the RIFF/WAVE stream parser: one byte per cycle in while not stalled.
// On the transfer of a byte the front end writes its command into the queue, and the
// back end registers the result from the queue head once out_stall lets it load.
// Throughput is one byte per cycle while the queue has room; a sample and final result
// that coincide go out as two transfers, and the queue stalls input at three commands.
// Reset clears all parse state and sets file_length to zero.
`default_nettype none
module riff_wave_stream_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       kind,
    output logic [31:0]      sample_bits,
    output logic [15:0]      num_channels,
    output logic [31:0]      sample_rate,
    output logic [2:0]       error_code,
    output logic             last
);
    logic [31:0]    file_length_reg;
    logic           take, active, cmd_valid, pop, not_empty, has_room;
    rwsp_pkg::cmd_t cmd, head;

    assign cfg_ready = 1'b1;
    assign in_stall = !has_room;
    assign take = in_valid && has_room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_length_reg <= '0;
        end
        else if (cfg_valid)
        begin
            file_length_reg <= cfg_data;
        end
    end

    rwsp_front u_front (
        .clk(clk), .rst_n(rst_n), .file_length(file_length_reg), .take(take),
        .data_byte(data_byte), .active(active), .cmd(cmd), .cmd_valid(cmd_valid)
    );

    rwsp_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(cmd_valid), .push_cmd(cmd), .pop(pop),
        .head(head), .not_empty(not_empty), .has_room(has_room)
    );

    rwsp_back u_back (
        .clk(clk), .rst_n(rst_n), .head(head), .not_empty(not_empty), .pop(pop),
        .stall(out_stall), .valid(out_valid), .kind(kind), .sample_bits(sample_bits),
        .num_channels(num_channels), .sample_rate(sample_rate),
        .error_code(error_code), .last(last)
    );
endmodule
`default_nettype wire

// ===== verif/rwsp_checker.sv =====
// Checker for the RIFF/WAVE stream parser: watches the configuration, byte and result
// channels, predicts every result from the accepted bytes and compares them in order.
// Depends on rwsp_pkg for the result kinds, error codes, chunk ids and phase names.
module rwsp_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [1:0]  kind,
    input  wire logic [31:0] sample_bits,
    input  wire logic [15:0] num_channels,
    input  wire logic [31:0] sample_rate,
    input  wire logic [2:0]  error_code,
    input  wire logic        last,
    output int               errors,
    output int               pending
);

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] bits;
        logic [15:0] chans;
        logic [31:0] rate;
        logic [2:0]  code;
        logic        last;
    } wav_result_t;

    wav_result_t result_q[$];

    logic [31:0]           flen;
    logic [31:0]           pos;
    rwsp_pkg::phase_t      phase;
    logic [31:0]           shift;
    logic [31:0]           remaining;
    logic [15:0]           fmt_tag;
    logic [15:0]           chans;
    logic [31:0]           rate;
    logic [15:0]           depth;
    logic                  seen_fmt;
    logic                  seen_data;
    logic                  seen_end;
    logic [31:0]           cid;
    rwsp_pkg::chunk_kind_t ck;
    logic [31:0]           off;
    logic                  pad;
    logic                  err_v;
    logic [2:0]            err_c;

    // The sample values are exact in single precision, so the double is narrowed by hand.
    function automatic logic [31:0] single_bits(input real r);
        logic [63:0] d;
        begin
            d = $realtobits(r);
            if (d[62:0] == 63'd0)
                single_bits = {d[63], 31'd0};
            else
                single_bits = {d[63], 8'(d[62:52] - 11'd896), d[51:29]};
        end
    endfunction

    task automatic add_result(input logic [1:0] k, input logic [31:0] b,
                              input logic [15:0] c, input logic [31:0] r,
                              input logic [2:0] e, input logic l);
        wav_result_t x;
        x.kind = k;
        x.bits = b;
        x.chans = c;
        x.rate = r;
        x.code = e;
        x.last = l;
        result_q.push_back(x);
    endtask

    task automatic latch_error(input logic [2:0] e);
        if (!err_v)
        begin
            err_v = 1'b1;
            err_c = e;
        end
        phase = rwsp_pkg::PH_IDLE;
    endtask

    task automatic close_body();
        off = '0;
        phase = pad ? rwsp_pkg::PH_PAD : rwsp_pkg::PH_HDR;
    endtask

    task automatic open_chunk(input logic [31:0] size);
        longint unsigned reach;
        remaining = size;
        off = '0;
        pad = size[0];
        ck = rwsp_pkg::CK_SKIP;
        reach = longint'(pos) + 64'd1 + longint'(size);
        if (reach > longint'(flen))
        begin
            phase = rwsp_pkg::PH_IDLE;
            return;
        end
        if (!seen_data)
        begin
            if (cid == rwsp_pkg::ID_FMT)
            begin
                if (size < 32'd16)
                begin
                    latch_error(rwsp_pkg::ERR_FMT);
                    return;
                end
                ck = rwsp_pkg::CK_FMT;
                seen_fmt = 1'b1;
            end
            else if (cid == rwsp_pkg::ID_DATA)
            begin
                if (!seen_fmt)
                begin
                    latch_error(rwsp_pkg::ERR_MISSING);
                    return;
                end
                if (fmt_tag != 16'd1 && fmt_tag != 16'd3)
                begin
                    latch_error(rwsp_pkg::ERR_FORMAT);
                    return;
                end
                if (chans == 16'd0)
                begin
                    latch_error(rwsp_pkg::ERR_CHANS);
                    return;
                end
                if (fmt_tag == 16'd1 && depth == 16'd16)
                    ck = rwsp_pkg::CK_D16;
                else if (fmt_tag == 16'd1 && depth == 16'd8)
                    ck = rwsp_pkg::CK_D8;
                else if (fmt_tag == 16'd3 && depth == 16'd32)
                    ck = rwsp_pkg::CK_F32;
                else
                begin
                    latch_error(rwsp_pkg::ERR_DEPTH);
                    return;
                end
                seen_data = 1'b1;
            end
        end
        if (size == 32'd0)
            close_body();
        else
            phase = rwsp_pkg::PH_BODY;
    endtask

    task automatic body_byte(input logic [7:0] b);
        int  s;
        real r;
        case (ck)
            rwsp_pkg::CK_FMT:
            begin
                if (off == 32'd1)
                    fmt_tag = shift[31:16];
                else if (off == 32'd3)
                    chans = shift[31:16];
                else if (off == 32'd7)
                    rate = shift;
                else if (off == 32'd15)
                    depth = shift[31:16];
            end
            rwsp_pkg::CK_D8:
            begin
                r = (real'(int'(b)) - 128.0) / 128.0;
                add_result(rwsp_pkg::KIND_SAMPLE, single_bits(r), '0, '0, '0, 1'b0);
            end
            rwsp_pkg::CK_D16:
            begin
                if (off[0])
                begin
                    s = int'($signed(shift[31:16]));
                    r = real'(s) / 32768.0;
                    add_result(rwsp_pkg::KIND_SAMPLE, single_bits(r), '0, '0, '0, 1'b0);
                end
            end
            rwsp_pkg::CK_F32:
            begin
                if (off[1:0] == 2'd3)
                    add_result(rwsp_pkg::KIND_SAMPLE, shift, '0, '0, '0, 1'b0);
            end
            default:
            begin
            end
        endcase
        off = off + 32'd1;
        remaining = remaining - 32'd1;
        if (remaining == 32'd0)
            close_body();
    endtask

    task automatic parse_byte(input logic [7:0] b);
        shift = {b, shift[31:8]};
        case (phase)
            rwsp_pkg::PH_RIFF:
            begin
                if (b != rwsp_pkg::ID_RIFF[8*pos[1:0] +: 8])
                    latch_error(rwsp_pkg::ERR_TAG);
                else if (pos >= 32'd3)
                    phase = rwsp_pkg::PH_SIZE;
            end
            rwsp_pkg::PH_SIZE:
            begin
                if (pos >= 32'd7)
                    phase = rwsp_pkg::PH_WAVE;
            end
            rwsp_pkg::PH_WAVE:
            begin
                if (b != rwsp_pkg::ID_WAVE[8*pos[1:0] +: 8])
                    latch_error(rwsp_pkg::ERR_TAG);
                else if (pos >= 32'd11)
                begin
                    phase = rwsp_pkg::PH_HDR;
                    off = '0;
                end
            end
            rwsp_pkg::PH_HDR:
            begin
                off = off + 32'd1;
                if (off == 32'd4)
                    cid = shift;
                else if (off >= 32'd8)
                    open_chunk(shift);
            end
            rwsp_pkg::PH_BODY:
                body_byte(b);
            rwsp_pkg::PH_PAD:
            begin
                phase = rwsp_pkg::PH_HDR;
                off = '0;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic predict_byte(input logic [7:0] b);
        if (seen_end || pos >= flen)
            return;
        if (flen >= rwsp_pkg::MIN_LENGTH)
            parse_byte(b);
        pos = pos + 32'd1;
        if (pos == flen)
        begin
            seen_end = 1'b1;
            if (flen < rwsp_pkg::MIN_LENGTH)
                add_result(rwsp_pkg::KIND_ERROR, '0, '0, '0, rwsp_pkg::ERR_SMALL, 1'b1);
            else if (err_v)
                add_result(rwsp_pkg::KIND_ERROR, '0, '0, '0, err_c, 1'b1);
            else if (seen_fmt && seen_data)
                add_result(rwsp_pkg::KIND_DONE, '0, chans, rate, '0, 1'b1);
            else
                add_result(rwsp_pkg::KIND_ERROR, '0, '0, '0, rwsp_pkg::ERR_MISSING, 1'b1);
        end
    endtask

    task automatic check_result();
        wav_result_t x;
        if (result_q.size() == 0)
        begin
            $display("%0t: unexpected result kind %0d bits %h", $time, kind, sample_bits);
            errors++;
            return;
        end
        x = result_q.pop_front();
        if (kind !== x.kind || sample_bits !== x.bits || num_channels !== x.chans ||
            sample_rate !== x.rate || error_code !== x.code || last !== x.last)
        begin
            $display("%0t: expected kind %0d bits %h ch %0d rate %0d code %0d last %0b",
                     $time, x.kind, x.bits, x.chans, x.rate, x.code, x.last);
            $display("%0t: actual   kind %0d bits %h ch %0d rate %0d code %0d last %0b",
                     $time, kind, sample_bits, num_channels, sample_rate, error_code, last);
            errors++;
        end
    endtask

    initial
    begin
        errors = 0;
        pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flen = '0;
            pos = '0;
            phase = rwsp_pkg::PH_RIFF;
            shift = '0;
            remaining = '0;
            fmt_tag = '0;
            chans = '0;
            rate = '0;
            depth = '0;
            seen_fmt = 1'b0;
            seen_data = 1'b0;
            seen_end = 1'b0;
            cid = '0;
            ck = rwsp_pkg::CK_SKIP;
            off = '0;
            pad = 1'b0;
            err_v = 1'b0;
            err_c = '0;
            result_q.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
                check_result();
            if (cfg_valid && cfg_ready)
                flen = cfg_data;
            if (in_valid && !in_stall)
                predict_byte(data_byte);
        end
        pending = result_q.size();
    end

endmodule

// ===== verif/testbench.sv =====
// Top of the RIFF/WAVE stream parser testbench: builds one WAVE file with random
// content, streams it in with random idling and reports the verdict of rwsp_checker.
// Depends on rwsp_pkg, riff_wave_stream_parser and rwsp_checker.
module testbench;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  kind;
    logic [31:0] sample_bits;
    logic [15:0] num_channels;
    logic [31:0] sample_rate;
    logic [2:0]  error_code;
    logic        last;
    int          errors;
    int          pending;
    logic        quiet;
    logic        long_hold;
    logic [7:0]  wav_bytes[$];

    riff_wave_stream_parser i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte),
        .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
        .sample_bits(sample_bits), .num_channels(num_channels),
        .sample_rate(sample_rate), .error_code(error_code), .last(last)
    );

    rwsp_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte),
        .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
        .sample_bits(sample_bits), .num_channels(num_channels),
        .sample_rate(sample_rate), .error_code(error_code), .last(last),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #1 clk = ~clk;
    end

    initial
    begin
        int cycles;
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 200000)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Receiver side: random stall bursts, one long hold on request, none when quiet.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            if (long_hold)
            begin
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                long_hold = 1'b0;
            end
            else if (quiet)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                out_stall <= ($urandom_range(0, 2) == 0);
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
        end
    end

    task automatic push_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            wav_bytes.push_back(w[8*i +: 8]);
    endtask

    task automatic push_half(input logic [15:0] h);
        wav_bytes.push_back(h[7:0]);
        wav_bytes.push_back(h[15:8]);
    endtask

    task automatic send_byte(input logic [7:0] b);
        logic taken;
        in_valid <= 1'b1;
        data_byte <= b;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    task automatic write_length(input logic [31:0] v);
        logic taken;
        cfg_valid <= 1'b1;
        cfg_data <= v;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    initial
    begin
        int          pick;
        int          data_len;
        int          data_start;
        int          split;
        logic [15:0] fmt_tag;
        logic [15:0] depth;
        logic [7:0]  extremes[16];

        extremes = '{8'h00, 8'h80, 8'hFF, 8'h7F, 8'h00, 8'h00, 8'hFF, 8'hFF,
                     8'h00, 8'h00, 8'h80, 8'h7F, 8'h01, 8'h00, 8'h80, 8'hFF};
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        data_byte = '0;
        quiet = 1'b0;
        long_hold = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With a zero file length every byte is ignored.
        for (int i = 0; i < 3; i++)
            send_byte(8'($urandom));
        drain();

        pick = $urandom_range(0, 2);
        fmt_tag = (pick == 2) ? 16'd3 : 16'd1;
        depth = (pick == 0) ? 16'd8 : (pick == 1) ? 16'd16 : 16'd32;
        data_len = $urandom_range(600, 760);

        push_word(rwsp_pkg::ID_RIFF);
        push_word($urandom);
        push_word(rwsp_pkg::ID_WAVE);
        push_word(32'h5453494C);
        push_word(32'd3);
        for (int i = 0; i < 4; i++)
            wav_bytes.push_back(8'($urandom));
        push_word(rwsp_pkg::ID_FMT);
        push_word(32'd18);
        push_half(fmt_tag);
        push_half(16'($urandom_range(1, 65535)));
        push_word($urandom);
        push_word($urandom);
        push_half(16'($urandom));
        push_half(depth);
        push_half(16'($urandom));
        push_word(rwsp_pkg::ID_DATA);
        push_word(data_len);
        data_start = wav_bytes.size();
        for (int i = 0; i < data_len; i++)
            wav_bytes.push_back(i < 16 ? extremes[i] : 8'($urandom));
        if (data_len % 2 == 1)
            wav_bytes.push_back(8'h00);
        // Chunks after the data chunk are skipped, and one that overruns ends the walk.
        push_word(rwsp_pkg::ID_FMT);
        push_word(32'd16);
        for (int i = 0; i < 16; i++)
            wav_bytes.push_back(8'($urandom));
        push_word(rwsp_pkg::ID_DATA);
        push_word(32'd2);
        push_half(16'($urandom));
        push_word(rwsp_pkg::ID_DATA);
        push_word(32'hFFFFFFF0);
        for (int i = 0; i < 5; i++)
            wav_bytes.push_back(8'($urandom));

        write_length(32'hFFFFFFFF);
        split = data_start + 40;
        for (int i = 0; i < split; i++)
        begin
            if (i == data_start + 8)
                long_hold = 1'b1;
            send_byte(wav_bytes[i]);
        end
        drain();

        write_length(wav_bytes.size());
        for (int i = split; i < wav_bytes.size(); i++)
        begin
            if (i == wav_bytes.size() - 100)
                quiet = 1'b1;
            send_byte(wav_bytes[i]);
        end
        drain();

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
